FILE: hw/rtl/rsvc_pkg.sv
// ----------------------------------------------------------------------------
// rsvc_pkg
// Types and constants shared by the valve command receiver modules.
// ----------------------------------------------------------------------------
package rsvc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned BodyW   = 3;

  localparam logic [ByteW-1:0] ChStart1 = 8'h25;
  localparam logic [ByteW-1:0] ChStart2 = 8'h24;
  localparam logic [ByteW-1:0] ChAt     = 8'h40;
  localparam logic [ByteW-1:0] ChD      = 8'h44;
  localparam logic [ByteW-1:0] ChR      = 8'h52;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;

  localparam logic [ByteW-1:0] NodeAddrReset = 8'h80;
  localparam logic [ByteW-1:0] TimeoutReset  = 8'd10;

  typedef enum logic [1:0] {
    ActByte    = 2'd0,
    ActTick    = 2'd1,
    ActRefresh = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegNodeAddress = 2'd0,
    RegTimeout     = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhAddr = 2'd1,
    PhBody = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] node_address;
    logic [ByteW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [ByteW-1:0] rx_byte;
    logic             power_fault;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] valve_pins;
    logic [ByteW-1:0] command_byte;
    logic             led_on;
    logic             line_busy;
    logic             frame_accepted;
    logic             timed_out;
  } result_t;

endpackage

FILE: hw/rtl/rsvc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rsvc_cfg_regs
// Configuration register file: node address and timeout in ticks.
// ----------------------------------------------------------------------------
module rsvc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rsvc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rsvc_pkg::ByteW-1:0]    cfg_data_i,
  output rsvc_pkg::cfg_t                cfg_o
);
  import rsvc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegNodeAddress: cfg_d.node_address  = cfg_data_i;
        RegTimeout:     cfg_d.timeout_ticks = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_address  <= NodeAddrReset;
      cfg_q.timeout_ticks <= TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/rsvc_engine.sv
// ----------------------------------------------------------------------------
// rsvc_engine
// Frame decoder, marker detectors, tick timer and valve pin register.
// ----------------------------------------------------------------------------
module rsvc_engine #(
  parameter int unsigned VALVE_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  rsvc_pkg::item_t   item_i,
  input  rsvc_pkg::cfg_t    cfg_i,
  output rsvc_pkg::result_t result_o
);
  import rsvc_pkg::*;

  localparam logic [ByteW-1:0] ValveMask = ByteW'((16'd1 << VALVE_COUNT) - 16'd1);

  phase_e           phase_q, phase_d;
  logic             addr_pend_q, addr_pend_d;
  logic [BodyW-1:0] body_idx_q, body_idx_d;
  logic             start_half_q, start_half_d;
  logic             end_half_q, end_half_d;
  logic             busy_q, busy_d;
  logic [ByteW-1:0] ticks_q, ticks_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] pins_q, pins_d;
  logic             led_q, led_d;
  logic             accepted, expired;
  logic [ByteW-1:0] ticks_inc;
  logic [ByteW-1:0] body_want;
  logic [ByteW-1:0] v;

  assign v         = item_i.rx_byte;
  assign ticks_inc = ticks_q + 8'd1;
  assign body_want = (body_idx_q == 3'd0) ? ChD : ChR;

  always_comb begin
    phase_d      = phase_q;
    addr_pend_d  = addr_pend_q;
    body_idx_d   = body_idx_q;
    start_half_d = start_half_q;
    end_half_d   = end_half_q;
    busy_d       = busy_q;
    ticks_d      = ticks_q;
    cmd_d        = cmd_q;
    pins_d       = pins_q;
    led_d        = led_q;
    accepted     = 1'b0;
    expired      = 1'b0;

    unique case (action_e'(item_i.action))
      ActByte: begin
        unique case (phase_q)
          PhAddr: begin
            if (addr_pend_q) begin
              if (v == cfg_i.node_address) begin
                phase_d    = PhBody;
                body_idx_d = '0;
              end else begin
                phase_d = PhHunt;
              end
              addr_pend_d = 1'b0;
            end else if (v == ChAt) begin
              addr_pend_d = 1'b1;
            end
          end
          PhBody: begin
            if (body_idx_q < 3'd2) begin
              if (v != body_want) begin
                phase_d = PhHunt;
                led_d   = 1'b0;
              end
            end else if (body_idx_q >= 3'd3) begin
              cmd_d    = v;
              phase_d  = PhHunt;
              ticks_d  = '0;
              led_d    = 1'b1;
              accepted = 1'b1;
            end
            body_idx_d = body_idx_q + 3'd1;
          end
          default: ;
        endcase

        if (start_half_q) begin
          if (v == ChStart2) begin
            start_half_d = 1'b0;
            phase_d      = PhAddr;
            body_idx_d   = '0;
            busy_d       = 1'b1;
          end
        end else if (v == ChStart1) begin
          start_half_d = 1'b1;
        end

        if (end_half_q) begin
          if (v == ChLf) begin
            end_half_d = 1'b0;
            busy_d     = 1'b0;
          end
        end else if (v == ChCr) begin
          end_half_d = 1'b1;
        end
      end
      ActTick: begin
        ticks_d = ticks_inc;
        if (ticks_inc > cfg_i.timeout_ticks) begin
          ticks_d = '0;
          cmd_d   = '0;
          led_d   = 1'b0;
          expired = 1'b1;
        end
      end
      ActRefresh: begin
        if (item_i.power_fault) begin
          cmd_d = '0;
        end
        pins_d = ~(cmd_d & ValveMask);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      addr_pend_q  <= 1'b0;
      body_idx_q   <= '0;
      start_half_q <= 1'b0;
      end_half_q   <= 1'b0;
      busy_q       <= 1'b0;
      ticks_q      <= '0;
      cmd_q        <= '0;
      pins_q       <= '1;
      led_q        <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      addr_pend_q  <= addr_pend_d;
      body_idx_q   <= body_idx_d;
      start_half_q <= start_half_d;
      end_half_q   <= end_half_d;
      busy_q       <= busy_d;
      ticks_q      <= ticks_d;
      cmd_q        <= cmd_d;
      pins_q       <= pins_d;
      led_q        <= led_d;
    end
  end

  always_comb begin
    result_o.valve_pins     = pins_d;
    result_o.command_byte   = cmd_d;
    result_o.led_on         = led_d;
    result_o.line_busy      = busy_d;
    result_o.frame_accepted = accepted;
    result_o.timed_out      = expired;
  end

endmodule

FILE: hw/rtl/rs485_valve_command_receiver.sv
// ----------------------------------------------------------------------------
// rs485_valve_command_receiver
// Multidrop serial frame receiver driving eight active-low valve pins.
// ----------------------------------------------------------------------------
// Input channel: one beat per event (received byte, timer tick or output
// refresh), taken when in_valid_i is high and in_stall_o is low.
// Output channel: one result beat per input beat, in order, with pin levels,
// held command, LED, line busy and the per-event frame and timeout flags.
// Configuration: cfg_valid_i/cfg_ready_o write node address (index 0) or
// timeout ticks (index 1); other indexes are ignored. Write only when idle.
// Path: a taken beat lands in the input register, is decoded by the engine
// and is loaded into the result register, from which it is presented.
// Throughput: one beat per cycle unless stalled; the decode is a single
// pass of the state update logic between the input and result registers.
// Reset: valves off (pins all high), command and LED cleared, decoder
// hunting for a start marker, node address 0x80, timeout 10 ticks.
// Stall: a valid result holds in the result register while out_stall_i is
// high; an empty input register still takes one beat, then in_stall_o rises.
// ----------------------------------------------------------------------------
module rs485_valve_command_receiver #(
  parameter int unsigned VALVE_COUNT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [rsvc_pkg::ByteW-1:0]    rx_byte_i,
  input  logic                          power_fault_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rsvc_pkg::ByteW-1:0]    valve_pins_o,
  output logic [rsvc_pkg::ByteW-1:0]    command_byte_o,
  output logic                          led_on_o,
  output logic                          line_busy_o,
  output logic                          frame_accepted_o,
  output logic                          timed_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rsvc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rsvc_pkg::ByteW-1:0]    cfg_data_i
);
  import rsvc_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_vld_q;
  result_t res_d, res_q;
  logic    res_vld_q;
  logic    out_free;
  logic    step;
  logic    in_take;

  assign out_free   = !res_vld_q || !out_stall_i;
  assign step       = item_vld_q && out_free;
  assign in_stall_o = item_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  rsvc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rsvc_engine #(
    .VALVE_COUNT (VALVE_COUNT)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_take) begin
      item_vld_q <= 1'b1;
    end else if (step) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action      <= action_i;
      item_q.rx_byte     <= rx_byte_i;
      item_q.power_fault <= power_fault_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (out_free) begin
      res_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = res_vld_q;
  assign valve_pins_o     = res_q.valve_pins;
  assign command_byte_o   = res_q.command_byte;
  assign led_on_o         = res_q.led_on;
  assign line_busy_o      = res_q.line_busy;
  assign frame_accepted_o = res_q.frame_accepted;
  assign timed_out_o      = res_q.timed_out;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RS-485 valve command receiver.
// Runs a handful of hand-picked events, then long runs of random frames
// (some corrupted) mixed with ticks, refreshes and stray bytes. Each runs
// under a different address and timeout setting. Input beats arrive in
// bursts with gaps and the result side stalls in patterns. A scoreboard
// predicts every result beat and checks each field in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsvc_pkg::*;

  localparam int unsigned ValveCnt  = 8;
  localparam int unsigned IdleLimit = 2000;
  localparam logic [ByteW-1:0] ValveMask = ByteW'((1 << ValveCnt) - 1);
  localparam logic [1:0] ActUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef enum int unsigned {StallNone, StallLight, StallHalf, StallHeavy} stall_mode_e;

  class valve_scoreboard;
    logic [ByteW-1:0] node_addr;
    logic [ByteW-1:0] timeout;
    phase_e           phase;
    bit               addr_pending;
    logic [BodyW-1:0] body_idx;
    bit               start_half;
    bit               end_half;
    bit               busy;
    logic [ByteW-1:0] ticks;
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] pins;
    bit               led;
    result_t          pending_q[$];
    int unsigned      errors;

    function new();
      node_addr    = NodeAddrReset;
      timeout      = TimeoutReset;
      phase        = PhHunt;
      addr_pending = 1'b0;
      body_idx     = '0;
      start_half   = 1'b0;
      end_half     = 1'b0;
      busy         = 1'b0;
      ticks        = '0;
      command      = '0;
      pins         = '1;
      led          = 1'b0;
      errors       = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        RegNodeAddress: node_addr = val;
        RegTimeout:     timeout   = val;
        default: ;
      endcase
    endfunction

    function void note_event(item_t it);
      result_t          r;
      bit               hit;
      bit               expired;
      logic [ByteW-1:0] b;
      hit     = 1'b0;
      expired = 1'b0;
      b       = it.rx_byte;
      case (it.action)
        ActByte: begin
          if (phase == PhAddr) begin
            if (addr_pending) begin
              if (b == node_addr) begin
                phase    = PhBody;
                body_idx = '0;
              end else begin
                phase = PhHunt;
              end
              addr_pending = 1'b0;
            end else if (b == ChAt) begin
              addr_pending = 1'b1;
            end
          end else if (phase == PhBody) begin
            if (body_idx < 2) begin
              if (b != ((body_idx == 0) ? ChD : ChR)) begin
                phase = PhHunt;
                led   = 1'b0;
              end
            end else if (body_idx >= 3) begin
              command = b;
              phase   = PhHunt;
              ticks   = '0;
              led     = 1'b1;
              hit     = 1'b1;
            end
            body_idx = body_idx + 1'b1;
          end
          if (start_half) begin
            if (b == ChStart2) begin
              start_half = 1'b0;
              phase      = PhAddr;
              body_idx   = '0;
              busy       = 1'b1;
            end
          end else if (b == ChStart1) begin
            start_half = 1'b1;
          end
          if (end_half) begin
            if (b == ChLf) begin
              end_half = 1'b0;
              busy     = 1'b0;
            end
          end else if (b == ChCr) begin
            end_half = 1'b1;
          end
        end
        ActTick: begin
          ticks = ticks + 1'b1;
          if (ticks > timeout) begin
            ticks   = '0;
            command = '0;
            led     = 1'b0;
            expired = 1'b1;
          end
        end
        ActRefresh: begin
          if (it.power_fault) command = '0;
          pins = ~(command & ValveMask);
        end
        default: ;
      endcase
      r.valve_pins     = pins;
      r.command_byte   = command;
      r.led_on         = led;
      r.line_busy      = busy;
      r.frame_accepted = hit;
      r.timed_out      = expired;
      pending_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [ByteW-1:0] want, logic [ByteW-1:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, seen);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: expected none, actual pins %h cmd %h",
                 $time, got.valve_pins, got.command_byte);
        return;
      end
      want = pending_q.pop_front();
      compare_field("valve_pins", want.valve_pins, got.valve_pins);
      compare_field("command_byte", want.command_byte, got.command_byte);
      compare_field("led_on", ByteW'(want.led_on), ByteW'(got.led_on));
      compare_field("line_busy", ByteW'(want.line_busy), ByteW'(got.line_busy));
      compare_field("frame_accepted", ByteW'(want.frame_accepted),
                    ByteW'(got.frame_accepted));
      compare_field("timed_out", ByteW'(want.timed_out), ByteW'(got.timed_out));
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [1:0]         action_i      = ActByte;
  logic [ByteW-1:0]   rx_byte_i     = '0;
  logic               power_fault_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [ByteW-1:0]   valve_pins_o;
  logic [ByteW-1:0]   command_byte_o;
  logic               led_on_o;
  logic               line_busy_o;
  logic               frame_accepted_o;
  logic               timed_out_o;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [ByteW-1:0]   cfg_data_i    = '0;

  valve_scoreboard sb = new();
  int unsigned     burst_left  = 0;
  int unsigned     items_sent  = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     stall_left  = 0;
  stall_mode_e     stall_mode  = StallNone;

  rs485_valve_command_receiver #(
    .VALVE_COUNT(ValveCnt)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .rx_byte_i       (rx_byte_i),
    .power_fault_i   (power_fault_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .valve_pins_o    (valve_pins_o),
    .command_byte_o  (command_byte_o),
    .led_on_o        (led_on_o),
    .line_busy_o     (line_busy_o),
    .frame_accepted_o(frame_accepted_o),
    .timed_out_o     (timed_out_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(8, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHalf:  out_stall_i <= ($urandom_range(0, 1) == 0);
      default:    out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin : result_monitor
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.valve_pins     = valve_pins_o;
      got.command_byte   = command_byte_o;
      got.led_on         = led_on_o;
      got.line_busy      = line_busy_o;
      got.frame_accepted = frame_accepted_o;
      got.timed_out      = timed_out_o;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic [1:0] act, logic [ByteW-1:0] b, logic pf);
    item_t       it;
    int unsigned gap;
    it.action      = act;
    it.rx_byte     = b;
    it.power_fault = pf;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    action_i      <= act;
    rx_byte_i     <= b;
    power_fault_i <= pf;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(it);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_register(idx, val);
    @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return ChStart1;
      1:       return ChStart2;
      2:       return ChAt;
      3:       return ChD;
      4:       return ChR;
      5:       return ChCr;
      6:       return ChLf;
      7:       return sb.node_addr;
      default: return ByteW'($urandom);
    endcase
  endfunction

  task automatic send_frame(int unsigned tick_pct);
    logic [ByteW-1:0] fr [8];
    fr = '{ChStart1, ChStart2, ChAt, sb.node_addr, ChD, ChR,
           ByteW'($urandom), ByteW'($urandom)};
    if ($urandom_range(0, 4) == 0) fr[$urandom_range(0, 7)] = pick_byte();
    foreach (fr[i]) begin
      if (i == 2 && $urandom_range(0, 5) == 0) send(ActByte, pick_byte(), 1'($urandom));
      send(ActByte, fr[i], 1'($urandom));
      if ($urandom_range(0, 99) < tick_pct / 4) send(ActTick, ByteW'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 2) != 0) begin
      send(ActByte, ChCr, 1'($urandom));
      if ($urandom_range(0, 4) == 0) send(ActByte, pick_byte(), 1'($urandom));
      send(ActByte, ChLf, 1'($urandom));
    end
    if ($urandom_range(0, 1) == 0)
      send(ActRefresh, ByteW'($urandom), ($urandom_range(0, 7) == 0));
  endtask

  task automatic send_noise(int unsigned tick_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < tick_pct)
      send(ActTick, ByteW'($urandom), 1'($urandom));
    else if (roll < tick_pct + (100 - tick_pct) / 2)
      send(ActByte, pick_byte(), 1'($urandom));
    else if (roll < 97)
      send(ActRefresh, ByteW'($urandom), ($urandom_range(0, 3) == 0));
    else
      send(ActUnused, ByteW'($urandom), 1'($urandom));
  endtask

  task automatic run_phase(logic [ByteW-1:0] addr, logic [ByteW-1:0] limit,
                           int unsigned count, int unsigned frame_pct,
                           int unsigned tick_pct);
    int unsigned first;
    drain();
    write_cfg(RegNodeAddress, addr);
    write_cfg(RegTimeout, limit);
    first = items_sent;
    while (items_sent - first < count) begin
      if ($urandom_range(0, 99) < frame_pct) send_frame(tick_pct);
      else send_noise(tick_pct);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(ActRefresh, 8'h00, 1'b0);
    send(ActUnused, 8'hFF, 1'b1);
    send(ActByte, ChStart1, 1'b0);
    send(ActByte, 8'h00, 1'b0);
    send(ActByte, ChStart2, 1'b1);
    send(ActByte, 8'h11, 1'b0);
    send(ActByte, ChAt, 1'b0);
    send(ActByte, NodeAddrReset, 1'b0);
    send(ActByte, ChD, 1'b0);
    send(ActByte, ChR, 1'b0);
    send(ActByte, 8'h00, 1'b0);
    send(ActByte, 8'hFF, 1'b0);
    send(ActRefresh, 8'hFF, 1'b0);
    send(ActRefresh, 8'h00, 1'b1);
    send(ActByte, ChCr, 1'b0);
    send(ActByte, 8'h00, 1'b0);
    send(ActByte, ChLf, 1'b0);
    send(ActByte, ChStart1, 1'b0);
    send(ActByte, ChStart2, 1'b0);
    send(ActByte, ChAt, 1'b0);
    send(ActByte, 8'h7F, 1'b0);
    send(ActByte, ChStart1, 1'b0);
    send(ActByte, ChStart2, 1'b0);
    send(ActByte, ChAt, 1'b0);
    send(ActByte, NodeAddrReset, 1'b0);
    send(ActByte, ChR, 1'b0);
    drain();
    write_cfg(RegTimeout, 8'd0);
    send(ActTick, 8'h00, 1'b0);

    run_phase(8'h00, 8'd0, 150, 60, 10);
    run_phase(8'hFF, 8'd254, 200, 10, 70);
    run_phase(ByteW'($urandom) | 8'h80, ByteW'($urandom_range(1, 20)), 250, 60, 30);
    run_phase(ChStart1, 8'd3, 150, 60, 30);
    drain();
    write_cfg(RegUnused, ByteW'($urandom));
    run_phase(ByteW'($urandom), 8'd255, 300, 5, 85);
    run_phase(NodeAddrReset, TimeoutReset, 100, 50, 25);

    drain();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rsvc_pkg.sv
hw/rtl/rsvc_cfg_regs.sv
hw/rtl/rsvc_engine.sv
hw/rtl/rs485_valve_command_receiver.sv
tb/tb.sv
